/* rtl/core/yrdc_pkg.sv */
// ============================================================================
// YUV 4:2:0 row delta codec - shared package
// Types, register indexes and reset values used across the codec core.
// ============================================================================
package yrdc_pkg;

  localparam int PIX_W            = 8;
  localparam int CFG_W            = 13;
  localparam int CFG_IDX_W        = 2;
  localparam int MAX_DIMENSION_DEF = 4096;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECODE_MODE  = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2
  } cfg_idx_e;

  // Planes in storage order.
  typedef enum logic [1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } plane_e;

  // Position information handed from the position tracker to the delta unit.
  typedef struct packed {
    logic row_start;
    logic frame_last;
  } pos_t;

endpackage

/* rtl/core/yrdc_pos_track.sv */
// ============================================================================
// YUV 4:2:0 row delta codec - position tracker
// Column, row and plane counters that mark row starts and the frame end.
// ============================================================================
module yrdc_pos_track #(
  parameter int MAX_DIMENSION = yrdc_pkg::MAX_DIMENSION_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [yrdc_pkg::CFG_W-1:0] frame_width_i,
  input  logic [yrdc_pkg::CFG_W-1:0] frame_height_i,
  output yrdc_pkg::pos_t             pos_o
);
  import yrdc_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIMENSION);
  localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
  localparam int CMP_W = (DIM_W > CFG_W) ? DIM_W : CFG_W;

  logic [CNT_W-1:0] col_q, col_d, row_q, row_d, col_eff, row_eff;
  plane_e           plane_q, plane_d, plane_eff, plane_nxt;
  logic [DIM_W-1:0] w, h, cw, ch, pw, ph;
  logic [DIM_W:0]   col_inc, row_inc;
  logic             chroma, restart, last_col, last_row, last_plane;

  // Zero acts as one and anything above the maximum acts as the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [CMP_W-1:0] v_ext;
    logic [CMP_W-1:0] max_ext;
    v_ext   = CMP_W'(v);
    max_ext = CMP_W'(MAX_DIMENSION);
    if (v_ext == '0) begin
      clamp_dim = DIM_W'(1);
    end else if (v_ext > max_ext) begin
      clamp_dim = DIM_W'(MAX_DIMENSION);
    end else begin
      clamp_dim = v_ext[DIM_W-1:0];
    end
  endfunction

  always_comb begin
    w      = clamp_dim(frame_width_i);
    h      = clamp_dim(frame_height_i);
    cw     = w >> 1;
    ch     = h >> 1;
    chroma = (cw != '0) && (ch != '0);

    // A chroma plane that has become empty sends the block back to luma.
    restart   = (plane_q != PLANE_Y) &&
                (!chroma || ((plane_q != PLANE_U) && (plane_q != PLANE_V)));
    col_eff   = restart ? '0 : col_q;
    row_eff   = restart ? '0 : row_q;
    plane_eff = restart ? PLANE_Y : plane_q;

    pw = (plane_eff == PLANE_Y) ? w : cw;
    ph = (plane_eff == PLANE_Y) ? h : ch;

    col_inc    = (DIM_W + 1)'(col_eff) + 1'b1;
    row_inc    = (DIM_W + 1)'(row_eff) + 1'b1;
    last_col   = col_inc >= {1'b0, pw};
    last_row   = row_inc >= {1'b0, ph};
    last_plane = (plane_eff == PLANE_V) || ((plane_eff == PLANE_Y) && !chroma);

    pos_o.row_start  = (col_eff == '0);
    pos_o.frame_last = last_col && last_row && last_plane;
  end

  always_comb begin
    unique case (plane_eff)
      PLANE_Y: plane_nxt = PLANE_U;
      PLANE_U: plane_nxt = PLANE_V;
      default: plane_nxt = PLANE_Y;
    endcase
  end

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    plane_d = plane_q;
    if (step_i) begin
      if (!last_col) begin
        col_d   = col_inc[CNT_W-1:0];
        row_d   = row_eff;
        plane_d = plane_eff;
      end else begin
        col_d = '0;
        if (!last_row) begin
          row_d   = row_inc[CNT_W-1:0];
          plane_d = plane_eff;
        end else begin
          row_d   = '0;
          plane_d = last_plane ? PLANE_Y : plane_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      plane_q <= PLANE_Y;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      plane_q <= plane_d;
    end
  end

endmodule

/* rtl/core/yrdc_delta_alu.sv */
// ============================================================================
// YUV 4:2:0 row delta codec - delta unit
// Row difference or row prefix sum of one byte against the carried byte.
// ============================================================================
module yrdc_delta_alu (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic                       decode_mode_i,
  input  yrdc_pkg::pos_t             pos_i,
  input  logic [yrdc_pkg::PIX_W-1:0] pixel_i,
  output logic [yrdc_pkg::PIX_W-1:0] result_o
);
  import yrdc_pkg::*;

  logic [PIX_W-1:0] carried_q, carried_d, prev;

  always_comb begin
    prev = pos_i.row_start ? '0 : carried_q;
    if (decode_mode_i) begin
      result_o  = prev + pixel_i;
      carried_d = result_o;
    end else begin
      result_o  = pixel_i - prev;
      carried_d = pixel_i;
    end
  end

  // The carried byte resets to zero and is updated only when a byte steps through.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carried_q <= '0;
    end else if (step_i) begin
      carried_q <= carried_d;
    end
  end

endmodule

/* rtl/core/yuv420_row_delta_codec_core.sv */
// ============================================================================
// YUV 4:2:0 row delta codec - top level
// Horizontal delta codec for planar 4:2:0 frames, one byte a cycle unless stalled.
// ============================================================================
// Usage: frame bytes enter on the input channel (in_valid_i, in_stall_o,
// pixel_in_i) in storage order: the Y plane, then U, then V. Each input
// transfer yields exactly one output transfer (out_valid_o, out_stall_i,
// pixel_out_o, frame_last_o), in order. In encode mode each output byte is
// the input byte minus its left neighbour modulo 256; in decode mode it is
// the running sum modulo 256 within the row. frame_last_o marks the final
// byte of a frame, after which the counters wrap to the next frame.
// An accepted byte is held in the input register and moves on to the
// result register, setting out_valid_o, once the result register is free
// or being emptied. Throughput is one byte per cycle while the receiver
// does not stall. The single 8-bit add or subtract and the counter
// increments lie between the two registers.
// When the receiver stalls, the result register holds its byte and the
// input register holds one more; in_stall_o is raised only then.
// Reset clears both register valid flags, the counters (luma plane, row and
// column zero), the carried byte, and loads encode mode at 640 by 480.
// Configuration is written through cfg_we_i, cfg_index_i and cfg_data_i
// while the block is idle; unknown indexes are ignored.
// ============================================================================
module yuv420_row_delta_codec_core #(
  parameter int MAX_DIMENSION = yrdc_pkg::MAX_DIMENSION_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [yrdc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [yrdc_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [yrdc_pkg::PIX_W-1:0]     pixel_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [yrdc_pkg::PIX_W-1:0]     pixel_out_o,
  output logic                           frame_last_o
);
  import yrdc_pkg::*;

  // Configuration registers.
  logic             decode_mode_q;
  logic [CFG_W-1:0] frame_width_q;
  logic [CFG_W-1:0] frame_height_q;

  // Input register and result register.
  logic             in_vld_q, in_vld_d;
  logic [PIX_W-1:0] in_pix_q;
  logic             out_vld_q, out_vld_d;
  logic [PIX_W-1:0] out_pix_q;
  logic             out_last_q;

  logic             accept, advance;
  pos_t             pos;
  logic [PIX_W-1:0] result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decode_mode_q  <= 1'b0;
      frame_width_q  <= WIDTH_RESET;
      frame_height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DECODE_MODE:  decode_mode_q  <= cfg_data_i[0];
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The held byte moves on whenever the result register is free or being emptied.
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_pix_q <= pixel_in_i;
    end
    if (advance) begin
      out_pix_q  <= result;
      out_last_q <= pos.frame_last;
    end
  end

  yrdc_pos_track #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_pos_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .frame_width_i (frame_width_q),
    .frame_height_i(frame_height_q),
    .pos_o         (pos)
  );

  yrdc_delta_alu u_delta_alu (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .decode_mode_i(decode_mode_q),
    .pos_i        (pos),
    .pixel_i      (in_pix_q),
    .result_o     (result)
  );

  assign out_valid_o  = out_vld_q;
  assign pixel_out_o  = out_pix_q;
  assign frame_last_o = out_last_q;

endmodule

/* rtl/core/yrdc_checker.sv */
// ============================================================================
// YUV 4:2:0 row delta codec - port checker
// Concurrent assertions on the top-level ports, bound to the codec core.
// ============================================================================
module yrdc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [yrdc_pkg::PIX_W-1:0] pixel_out_o,
  input logic                       frame_last_o
);

  // A stalled output stays valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  // A stalled output keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pixel_out_o) && $stable(frame_last_o))
    else $error("output payload changed while stalled");

  // The input side is only held back by a stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without downstream back-pressure");

  // A result appearing on an idle output came from an input transfer through the input and result registers.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result appeared without a matching input transfer");

endmodule

bind yuv420_row_delta_codec_core yrdc_checker u_yrdc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .pixel_out_o (pixel_out_o),
  .frame_last_o(frame_last_o)
);

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// Testbench for the YUV 4:2:0 row delta codec core
// Streams frame bytes through the core under a range of frame sizes and both
// coding modes, with random gaps and stalls, and checks every output byte and
// frame-end flag against an in-bench prediction of the row delta coder.
// ----------------------------------------------------------------------------
module tb;
  import yrdc_pkg::*;

  // Idle cycles without any transfer before the run is declared hung. The
  // slowest correct stretch is one sender gap, one receiver stall, the
  // two-stage pipeline and a configuration pause, far below this.
  localparam int HANG_LIMIT = 2000;
  // Bytes to push through the random phases.
  localparam int TARGET_ITEMS = 1350;

  // One predicted output transfer.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } coded_pixel_t;

  // Scoreboard: carries its own copy of the registers and the position
  // counters, predicts each output byte when the matching input transfer is
  // seen, and compares output transfers against the oldest prediction.
  class row_delta_scoreboard;
    logic             decode_mode;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [11:0]      column_pos;
    logic [11:0]      row_pos;
    plane_e           plane;
    logic [PIX_W-1:0] carried;
    coded_pixel_t     expected_q[$];
    int               mismatches;
    int               inputs_seen;
    int               results_seen;
    int               frames_seen;

    function new();
      decode_mode  = 1'b0;
      width_reg    = WIDTH_RESET;
      height_reg   = HEIGHT_RESET;
      column_pos   = '0;
      row_pos      = '0;
      plane        = PLANE_Y;
      carried      = '0;
      mismatches   = 0;
      inputs_seen  = 0;
      results_seen = 0;
      frames_seen  = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_DECODE_MODE:  decode_mode = value[0];
        CFG_FRAME_WIDTH:  width_reg   = value;
        CFG_FRAME_HEIGHT: height_reg  = value;
        default: ;
      endcase
    endfunction

    // Zero acts as one, anything beyond the largest size as the largest size.
    static function int clamp_dim(logic [CFG_W-1:0] v);
      if (v == '0) return 1;
      if (int'(v) > MAX_DIMENSION_DEF) return MAX_DIMENSION_DEF;
      return int'(v);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(logic [PIX_W-1:0] px);
      int           w, h, cw, ch, pw, ph;
      bit           chroma, last_col, last_row, last_plane;
      logic [PIX_W-1:0] prev;
      coded_pixel_t res;
      inputs_seen++;
      w      = clamp_dim(width_reg);
      h      = clamp_dim(height_reg);
      cw     = w / 2;
      ch     = h / 2;
      chroma = (cw != 0) && (ch != 0);
      // A chroma plane that has vanished under new sizes restarts the frame.
      if (plane != PLANE_Y && !chroma) begin
        plane      = PLANE_Y;
        column_pos = '0;
        row_pos    = '0;
      end
      if (plane == PLANE_Y) begin
        pw = w;
        ph = h;
      end else begin
        pw = cw;
        ph = ch;
      end
      prev = (column_pos == '0) ? '0 : carried;
      if (decode_mode) begin
        res.pixel = prev + px;
        carried   = res.pixel;
      end else begin
        res.pixel = px - prev;
        carried   = px;
      end
      last_col   = int'(column_pos) + 1 >= pw;
      last_row   = int'(row_pos) + 1 >= ph;
      last_plane = (plane == PLANE_V) || (plane == PLANE_Y && !chroma);
      res.last   = last_col && last_row && last_plane;
      expected_q.push_back(res);
      if (!last_col) begin
        column_pos++;
      end else begin
        column_pos = '0;
        if (!last_row) begin
          row_pos++;
        end else begin
          row_pos = '0;
          if (last_plane) plane = PLANE_Y;
          else plane = (plane == PLANE_Y) ? PLANE_U : PLANE_V;
        end
      end
    endfunction

    task report(string what, int got, int want);
      $display("MISMATCH at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_result(logic [PIX_W-1:0] px, logic last);
      coded_pixel_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report("output transfer with nothing outstanding, pixel_out", px, -1);
        return;
      end
      want = expected_q.pop_front();
      if (px !== want.pixel) report("pixel_out", px, want.pixel);
      if (last !== want.last) report("frame_last", last, want.last);
      if (want.last) frames_seen++;
    endtask
  endclass

  // Every input of the core holds a known value from time zero, with reset
  // asserted.
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_DECODE_MODE;
  logic [CFG_W-1:0]     cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [PIX_W-1:0]     pixel_in_i  = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [PIX_W-1:0]     pixel_out_o;
  logic                 frame_last_o;

  row_delta_scoreboard sb = new();

  // When set, neither side inserts gaps or stalls, so the core runs flat out.
  bit steady      = 1'b0;
  int idle_cycles = 0;
  int phase_count = 0;

  yuv420_row_delta_codec_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_in_i   (pixel_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_out_o  (pixel_out_o),
    .frame_last_o (frame_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Monitor and watchdog. All values are sampled as they stood just before
  // the edge, since every input is driven with nonblocking assignments and
  // the core's registers update in the same region.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_input(pixel_in_i);
      if (out_valid_o && !out_stall_i) sb.check_result(pixel_out_o, frame_last_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= HANG_LIMIT) begin
        $display("Timed out with %0d results outstanding.", sb.pending());
        $display("yuv420_row_delta_codec_core verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: before each output transfer it holds stall high for a random
  // number of cycles, then takes the next valid byte.
  initial begin
    int hold;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 13);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
      while (out_valid_o !== 1'b1) @(posedge clk_i);
    end
  end

  // Writes the registers picked by mask, one per cycle. Only called while
  // the core is idle, so the predictor may take the new value at once.
  task automatic write_config(input logic [2:0] mask, input logic dmode,
                              input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    logic [CFG_W-1:0] vals[3];
    vals[CFG_DECODE_MODE]  = {{(CFG_W-1){1'b0}}, dmode};
    vals[CFG_FRAME_WIDTH]  = w;
    vals[CFG_FRAME_HEIGHT] = h;
    for (int i = 0; i < 3; i++) begin
      if (mask[i]) begin
        cfg_we_i    <= 1'b1;
        cfg_index_i <= cfg_idx_e'(i);
        cfg_data_i  <= vals[i];
        sb.write_reg(cfg_idx_e'(i), vals[i]);
        @(posedge clk_i);
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  // Sends a batch of bytes, each after a random gap. Valid stays high from
  // one byte to the next when there is no gap, and the payload is held until
  // the transfer completes.
  task automatic send_batch(input logic [PIX_W-1:0] bytes_q[$]);
    int gap;
    foreach (bytes_q[k]) begin
      gap = steady ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      pixel_in_i <= bytes_q[k];
      @(posedge clk_i);
      while (in_stall_o !== 1'b0) @(posedge clk_i);
    end
    in_valid_i <= 1'b0;
  endtask

  // Waits until every predicted byte has come out, then lets the pipeline
  // settle so the core is truly idle.
  task automatic wait_idle();
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    phase_count++;
  endtask

  // Sizes are mostly tiny so frames finish often; now and then a size of
  // zero, the largest legal one, or one beyond it.
  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 29))
      0:       return '0;
      1:       return CFG_W'(MAX_DIMENSION_DEF);
      2:       return '1;
      3:       return CFG_W'(MAX_DIMENSION_DEF + 1);
      default: return CFG_W'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    logic [PIX_W-1:0] batch[$];
    int               n;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: encode at 640 by 480, bytes at both ends of the range.
    batch = '{8'h00, 8'hFF, 8'h01, 8'h80};
    send_batch(batch);
    wait_idle();

    // Decode on a 2 by 2 frame from mid-row in luma: one byte ends that
    // row, then two luma bytes, one U and one V byte end the frame.
    write_config(3'b111, 1'b1, 13'd2, 13'd2);
    batch = '{8'hFF, 8'h01, 8'h7F, 8'h80, 8'hAA};
    send_batch(batch);
    wait_idle();

    // Width zero acts as one and chroma vanishes, so each row is one byte:
    // the third byte ends the frame and the fourth starts a fresh one.
    write_config(3'b111, 1'b0, 13'd0, 13'd3);
    batch = '{8'h10, 8'h20, 8'hFF, 8'h00};
    send_batch(batch);
    wait_idle();

    // Width beyond the limit, height zero: one luma row of the largest size,
    // no chroma, left part-way along the row.
    write_config(3'b111, 1'b1, '1, 13'd0);
    batch = '{8'h55, 8'hAA, 8'hFF};
    send_batch(batch);
    wait_idle();

    // Mode flips mid-row, and the column counter is already past the new
    // last column, so the first byte here closes its row.
    write_config(3'b111, 1'b0, 13'd3, 13'd5);
    batch = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};
    send_batch(batch);
    wait_idle();

    // Random phases: a fresh mix of register writes, then a run of bytes.
    // The counters are not cleared between phases, so size changes land at
    // arbitrary positions within a frame.
    while (sb.inputs_seen < TARGET_ITEMS) begin
      steady = ($urandom_range(0, 3) == 0);
      write_config(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), pick_dim(),
                   pick_dim());
      n = $urandom_range(10, 70);
      batch.delete();
      repeat (n) batch.push_back(pick_pixel());
      send_batch(batch);
      wait_idle();
    end
    steady = 1'b0;

    $display("Covered %0d input transfers over %0d configuration phases.",
             sb.inputs_seen, phase_count);
    $display("Checked %0d output transfers, %0d frame ends, %0d mismatches.",
             sb.results_seen, sb.frames_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("yuv420_row_delta_codec_core verification clean");
    end else begin
      $display("yuv420_row_delta_codec_core verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/yrdc_pkg.sv
rtl/core/yrdc_pos_track.sv
rtl/core/yrdc_delta_alu.sv
rtl/core/yuv420_row_delta_codec_core.sv
rtl/core/yrdc_checker.sv
sim/tb.sv
